// ----- src/b40nd_pkg.sv -----
`default_nettype none

package b40nd_pkg;

    // Field widths
    localparam int CODE_W  = 64;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 6;

    // Base-40 digits held for one name
    localparam int MAX_DIGITS = 13;
    localparam int IDX_W      = $clog2(MAX_DIGITS);

    // Conversion consumes three code bits per cycle, code padded to a multiple of three
    localparam int GROUP_W    = 3;
    localparam int NUM_GROUPS = (CODE_W + GROUP_W - 1) / GROUP_W;
    localparam int SHIFT_W    = NUM_GROUPS * GROUP_W;
    localparam int CNT_W      = $clog2(NUM_GROUPS);

    // ASCII codes
    localparam logic [CHAR_W-1:0] ASCII_SPACE  = 7'h20;
    localparam logic [CHAR_W-1:0] ASCII_PERIOD = 7'h2e;
    localparam logic [CHAR_W-1:0] ASCII_NUL    = 7'h00;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SCAN,
        S_EMIT,
        S_EMPTY
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic conv_step;
        logic scan;
        logic emit_load;
        logic empty_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic code_zero;
        logic ptr_zero;
        logic out_free;
    } t_status;

    // Quotient of a base-40 digit divided by 5 (digit below 40 gives 0..7)
    function automatic logic [GROUP_W-1:0] quo5(input logic [DIGIT_W-1:0] d);
        logic [GROUP_W-1:0] q;
        begin
            priority if (d >= 6'd35) q = 3'd7;
            else if (d >= 6'd30)     q = 3'd6;
            else if (d >= 6'd25)     q = 3'd5;
            else if (d >= 6'd20)     q = 3'd4;
            else if (d >= 6'd15)     q = 3'd3;
            else if (d >= 6'd10)     q = 3'd2;
            else if (d >= 6'd5)      q = 3'd1;
            else                     q = 3'd0;
            return q;
        end
    endfunction

    // Remainder of a base-40 digit divided by 5
    function automatic logic [GROUP_W-1:0] rem5(input logic [DIGIT_W-1:0] d);
        logic [GROUP_W-1:0] q;
        logic [DIGIT_W-1:0] five_q;
        logic [DIGIT_W-1:0] r;
        begin
            q      = quo5(d);
            five_q = {1'b0, q, 2'b00} + {3'b000, q};
            r      = d - five_q;
            return r[GROUP_W-1:0];
        end
    endfunction

    // Map a base-40 digit to its character
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        begin
            priority if (d == 6'd0)          c = ASCII_SPACE;
            else if (d <= 6'd26)             c = 7'd96 + {1'b0, d};
            else if (d == 6'd28)             c = ASCII_PERIOD;
            else if (d >= 6'd30 && d <= 6'd39) c = 7'd18 + {1'b0, d};
            else                             c = ASCII_SPACE;
            return c;
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/b40nd_ctrl.sv -----
`default_nettype none

module b40nd_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire b40nd_pkg::t_status i_status,
    output b40nd_pkg::t_cmd       o_cmd
);

    b40nd_pkg::t_state                 r_state, n_state;
    logic [b40nd_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic                              w_conv_done;

    assign w_conv_done = (r_cnt == b40nd_pkg::CNT_W'(b40nd_pkg::NUM_GROUPS - 1));

    // Hold state and group counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= b40nd_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Sequence load, conversion, scan and character output
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            b40nd_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                n_cnt      = '0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.code_zero) begin
                        n_state = b40nd_pkg::S_EMPTY;
                    end else begin
                        n_state = b40nd_pkg::S_CONV;
                    end
                end
            end
            b40nd_pkg::S_CONV: begin
                o_cmd.conv_step = 1'b1;
                n_cnt           = r_cnt + b40nd_pkg::CNT_W'(1);
                if (w_conv_done) begin
                    n_cnt   = '0;
                    n_state = b40nd_pkg::S_SCAN;
                end
            end
            b40nd_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_state    = b40nd_pkg::S_EMIT;
            end
            b40nd_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_status.ptr_zero) begin
                        n_state = b40nd_pkg::S_IDLE;
                    end
                end
            end
            b40nd_pkg::S_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.empty_load = 1'b1;
                    n_state          = b40nd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = b40nd_pkg::S_IDLE;
            end
        endcase
    end

    // Counter only advances during conversion
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != b40nd_pkg::S_CONV) |-> (r_cnt == '0))
        else $error("group counter nonzero outside conversion");

    // Scan is entered only straight from conversion
    a_scan_after_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == b40nd_pkg::S_SCAN) |-> ($past(r_state) == b40nd_pkg::S_CONV))
        else $error("scan entered without conversion");

    // Input is taken only when idle
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == b40nd_pkg::S_IDLE))
        else $error("load outside idle");

endmodule

`default_nettype wire

// ----- src/b40nd_dp.sv -----
`default_nettype none

module b40nd_dp (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire  [b40nd_pkg::CODE_W-1:0]          i_packed_code,
    input  wire  b40nd_pkg::t_cmd                 i_cmd,
    output b40nd_pkg::t_status                    o_status,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output logic [b40nd_pkg::CHAR_W-1:0]          o_char_out,
    output logic                                  o_empty_name,
    output logic                                  o_last_char
);

    logic [b40nd_pkg::SHIFT_W-1:0]  r_shift, n_shift;
    logic [b40nd_pkg::DIGIT_W-1:0]  r_digit [b40nd_pkg::MAX_DIGITS];
    logic [b40nd_pkg::DIGIT_W-1:0]  n_digit [b40nd_pkg::MAX_DIGITS];
    logic [b40nd_pkg::IDX_W-1:0]    r_ptr, n_ptr;
    logic [b40nd_pkg::IDX_W-1:0]    w_top;
    logic                           r_out_valid, n_out_valid;
    logic [b40nd_pkg::CHAR_W-1:0]   r_char, n_char;
    logic                           r_empty, n_empty;
    logic                           r_last, n_last;
    logic [b40nd_pkg::GROUP_W-1:0]  w_group;

    assign w_group = r_shift[b40nd_pkg::SHIFT_W-1 -: b40nd_pkg::GROUP_W];

    // Shift in three code bits: each digit becomes 8*(d mod 5) + carry from below
    always_comb begin
        n_shift = r_shift;
        for (int i = 0; i < b40nd_pkg::MAX_DIGITS; i++) begin
            n_digit[i] = r_digit[i];
        end
        if (i_cmd.load) begin
            n_shift = {{(b40nd_pkg::SHIFT_W - b40nd_pkg::CODE_W){1'b0}}, i_packed_code};
            for (int i = 0; i < b40nd_pkg::MAX_DIGITS; i++) begin
                n_digit[i] = '0;
            end
        end else if (i_cmd.conv_step) begin
            n_shift    = r_shift << b40nd_pkg::GROUP_W;
            n_digit[0] = {b40nd_pkg::rem5(r_digit[0]), w_group};
            for (int i = 1; i < b40nd_pkg::MAX_DIGITS; i++) begin
                n_digit[i] = {b40nd_pkg::rem5(r_digit[i]), b40nd_pkg::quo5(r_digit[i-1])};
            end
        end
    end

    // Find the most significant nonzero digit
    always_comb begin
        w_top = '0;
        for (int i = 0; i < b40nd_pkg::MAX_DIGITS; i++) begin
            if (r_digit[i] != '0) begin
                w_top = b40nd_pkg::IDX_W'(i);
            end
        end
    end

    // Walk the pointer down from the top digit
    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.scan) begin
            n_ptr = w_top;
        end else if (i_cmd.emit_load) begin
            n_ptr = r_ptr - b40nd_pkg::IDX_W'(1);
        end
    end

    // Load the output register or drop it after a transfer
    always_comb begin
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_empty     = r_empty;
        n_last      = r_last;
        if (i_cmd.emit_load) begin
            n_out_valid = 1'b1;
            n_char      = b40nd_pkg::digit_to_char(r_digit[r_ptr]);
            n_empty     = 1'b0;
            n_last      = (r_ptr == '0);
        end else if (i_cmd.empty_load) begin
            n_out_valid = 1'b1;
            n_char      = b40nd_pkg::ASCII_NUL;
            n_empty     = 1'b1;
            n_last      = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_ptr   <= n_ptr;
        r_char  <= n_char;
        r_empty <= n_empty;
        r_last  <= n_last;
        for (int i = 0; i < b40nd_pkg::MAX_DIGITS; i++) begin
            r_digit[i] <= n_digit[i];
        end
    end

    assign o_status.code_zero = (i_packed_code == '0);
    assign o_status.ptr_zero  = (r_ptr == '0);
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_char_out   = r_char;
    assign o_empty_name = r_empty;
    assign o_last_char  = r_last;

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_load || i_cmd.empty_load) |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

    // Commands exclude each other
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.load, i_cmd.conv_step, i_cmd.scan, i_cmd.emit_load, i_cmd.empty_load}))
        else $error("more than one datapath command");

    // A nonzero code leaves a nonzero leading digit
    a_top_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |=> (r_digit[r_ptr] != '0))
        else $error("leading digit is zero after scan");

endmodule

`default_nettype wire

// ----- src/base40_name_decoder_top.sv -----
`default_nettype none

// Base-40 name decoder.
// Input channel: i_in_valid / o_in_stall carry one 64-bit packed name on
// i_packed_code. Output channel: o_out_valid / i_out_stall carry one
// character per transfer on o_char_out, with o_last_char on the final one.
// A zero code gives a single transfer with o_empty_name and o_last_char set.
// Sequence: after a code is taken, a conversion turns it into 13
// base-40 digits, three code bits per cycle, then a scan finds the
// leading digit. The first character is then loaded into the output
// register and the rest follow one per cycle while the output does not
// stall; a zero code goes straight to the single empty-name transfer.
// The next code is taken as soon as the last character is loaded, while that
// character may still wait in the output register.
// A stall on the output holds the output register and pauses the character
// walk; nothing is lost. Reset (synchronous, active low) empties the output
// register and returns the controller to idle.
module base40_name_decoder_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire  [b40nd_pkg::CODE_W-1:0]       i_packed_code,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic [b40nd_pkg::CHAR_W-1:0]       o_char_out,
    output logic                               o_empty_name,
    output logic                               o_last_char
);

    b40nd_pkg::t_cmd    w_cmd;
    b40nd_pkg::t_status w_status;

    b40nd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    b40nd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_packed_code (i_packed_code),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_char_out    (o_char_out),
        .o_empty_name  (o_empty_name),
        .o_last_char   (o_last_char)
    );

endmodule

`default_nettype wire
